### rtl/core/wavetable_generator_defines.svh
// Assertion macros used by the wavetable generator port checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef WAVETABLE_GENERATOR_DEFINES_SVH
`define WAVETABLE_GENERATOR_DEFINES_SVH

// property must hold at every clock edge outside reset
`define WTG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("wavetable_generator: assertion failed");

// condition must never be seen outside reset
`define WTG_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("wavetable_generator: forbidden condition seen");

`endif

### rtl/core/wtg_pkg.sv
// Wavetable generator package: widths, codes, register map, reset values, noise
// seeds and the config/control/status structs. No dependencies.
`default_nettype none

package wtg_pkg;

	localparam int unsigned TABLE_SIZE_DEF = 1024;
	localparam int unsigned DATA_W         = 32;
	localparam int unsigned IDX_W          = 10;
	localparam int unsigned SAMPLE_W       = 16;
	localparam int unsigned COEF_W         = 15;
	localparam int unsigned KIND_W         = 2;
	localparam int unsigned PADDR_W        = 4;
	localparam int unsigned PDATA_W        = 32;
	localparam int unsigned REG_IDX_W      = 2;
	localparam int unsigned QUO_W          = 31;
	localparam int unsigned DCNT_W         = 5;

	localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TRI    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RAMP   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NOISE  = 2'd3;

	localparam logic ACT_BUILD = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	localparam logic [REG_IDX_W-1:0] REG_KIND = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SOFT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COEF = 2'd2;

	localparam logic [KIND_W-1:0] KIND_RST = KIND_SQUARE;
	localparam logic              SOFT_RST = 1'b0;
	localparam logic [COEF_W-1:0] COEF_RST = 15'd33;

	localparam logic [DATA_W-1:0] NOISE_SEED1 = 32'h6745_2301;
	localparam logic [DATA_W-1:0] NOISE_SEED2 = 32'hefcd_ab89;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              soft_en;
		logic [COEF_W-1:0] coef;
	} cfg_t;

	typedef struct packed {
		logic rd_start;
		logic build_start;
		logic fill_wr;
		logic sm_mul;
		logic sm_wr;
		logic nr_rd;
		logic nr_ld;
		logic nr_step;
		logic nr_wr;
		logic build_ack;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic div_last;
		logic peak_zero;
		logic out_free;
		logic rd_pending;
	} sts_t;

endpackage

`default_nettype wire

### rtl/core/wtg_if.sv
// Request and response channel interfaces of the wavetable generator.
// Depends on wtg_pkg.
`default_nettype none

interface wtg_req_if;
	import wtg_pkg::*;
	logic             valid;
	logic             ready;
	logic             action;
	logic [IDX_W-1:0] index;
	modport source (output valid, output action, output index, input ready);
	modport sink (input valid, input action, input index, output ready);
endinterface

interface wtg_rsp_if;
	import wtg_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       built;
	modport source (output valid, output sample, output built, input ready);
	modport sink (input valid, input sample, input built, output ready);
endinterface

`default_nettype wire

### rtl/core/wtg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wtg_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/wtg_regs.sv
// APB configuration registers: wave kind, smoothing enable, coefficient.
// Depends on wtg_pkg.
`default_nettype none

module wtg_regs (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [wtg_pkg::PADDR_W-1:0]     paddr,
	input  wire [wtg_pkg::PDATA_W-1:0]     pwdata,
	output logic [wtg_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	output wtg_pkg::cfg_t                  cfg
);
	import wtg_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kind    <= KIND_RST;
			cfg_q.soft_en <= SOFT_RST;
			cfg_q.coef    <= COEF_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_KIND: cfg_q.kind    <= pwdata[KIND_W-1:0];
				REG_SOFT: cfg_q.soft_en <= pwdata[0];
				REG_COEF: cfg_q.coef    <= pwdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_KIND: prdata = PDATA_W'(cfg_q.kind);
			REG_SOFT: prdata = PDATA_W'(cfg_q.soft_en);
			REG_COEF: prdata = PDATA_W'(cfg_q.coef);
			default:  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/wtg_ctrl.sv
// Build/read sequencer: accepts items, steps the fill, smoothing and
// normalization passes. Depends on wtg_pkg.
`default_nettype none

module wtg_ctrl (
	input  wire           clk,
	input  wire           arst_n,
	input  wtg_pkg::cfg_t cfg,
	input  wire           req_valid,
	input  wire           req_action,
	output logic          req_ready,
	input  wtg_pkg::sts_t sts,
	output wtg_pkg::cmd_t cmd
);
	import wtg_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FILL   = 4'd1;
	localparam logic [3:0] S_SM_MUL = 4'd2;
	localparam logic [3:0] S_SM_WR  = 4'd3;
	localparam logic [3:0] S_NR_RD  = 4'd4;
	localparam logic [3:0] S_NR_LD  = 4'd5;
	localparam logic [3:0] S_NR_DIV = 4'd6;
	localparam logic [3:0] S_NR_WR  = 4'd7;
	localparam logic [3:0] S_DONE   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       accept;
	logic       smooth_en;

	assign req_ready = (state_q == S_IDLE) && (!sts.rd_pending || sts.out_free);
	assign accept    = req_valid && req_ready;
	assign smooth_en = cfg.soft_en && (cfg.kind != KIND_NOISE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_action == ACT_READ) begin
						cmd.rd_start = 1'b1;
					end else begin
						cmd.build_start = 1'b1;
						state_d = smooth_en ? S_SM_MUL : S_FILL;
					end
				end
			end
			S_FILL: begin
				cmd.fill_wr = 1'b1;
				if (sts.last) begin
					state_d = S_DONE;
				end
			end
			S_SM_MUL: begin
				cmd.sm_mul = 1'b1;
				state_d = S_SM_WR;
			end
			S_SM_WR: begin
				cmd.sm_wr = 1'b1;
				state_d = sts.last ? S_NR_RD : S_SM_MUL;
			end
			S_NR_RD: begin
				if (sts.peak_zero) begin
					state_d = S_DONE;
				end else begin
					cmd.nr_rd = 1'b1;
					state_d = S_NR_LD;
				end
			end
			S_NR_LD: begin
				cmd.nr_ld = 1'b1;
				state_d = S_NR_DIV;
			end
			S_NR_DIV: begin
				cmd.nr_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_NR_WR;
				end
			end
			S_NR_WR: begin
				cmd.nr_wr = 1'b1;
				state_d = sts.last ? S_DONE : S_NR_RD;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.build_ack = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/wtg_dp.sv
// Datapath: shape generator, noise source, smoothing MAC, restoring divider,
// table RAM and the read/output pipeline. Depends on wtg_pkg, wtg_ram.
`default_nettype none

module wtg_dp #(
	parameter int unsigned TABLE_SIZE = wtg_pkg::TABLE_SIZE_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wtg_pkg::cfg_t                      cfg,
	input  wtg_pkg::cmd_t                      cmd,
	output wtg_pkg::sts_t                      sts,
	input  wire [wtg_pkg::IDX_W-1:0]           req_index,
	input  wire                                rsp_ready,
	output logic                               rsp_valid,
	output logic signed [wtg_pkg::SAMPLE_W-1:0] rsp_sample,
	output logic                               rsp_built
);
	import wtg_pkg::*;

	localparam int unsigned AW      = $clog2(TABLE_SIZE);
	localparam int unsigned SH_TRI  = 32 - AW;
	localparam int unsigned SH_RAMP = 31 - AW;
	localparam logic [AW:0]   QTR    = (AW+1)'(TABLE_SIZE / 4);
	localparam logic [AW:0]   MID_HI = (AW+1)'(TABLE_SIZE / 4 + TABLE_SIZE / 2);
	localparam logic [AW-1:0] HALF   = AW'(TABLE_SIZE / 2);
	localparam logic [AW-1:0] LAST   = AW'(TABLE_SIZE - 1);
	localparam logic signed [33:0] ONE34   = 34'sd1073741824;
	localparam logic signed [33:0] THREE34 = 34'sd3221225472;
	localparam logic signed [48:0] RND15   = 49'sd16384;
	localparam logic signed [32:0] RND_RD  = 33'sd16384;
	localparam logic signed [17:0] SAT_HI  = 18'sd32767;
	localparam logic signed [17:0] SAT_LO  = -18'sd32768;

	function automatic logic [DATA_W-1:0] shape_val(logic [KIND_W-1:0] kind,
		logic [AW-1:0] i);
		logic [AW:0]       ie;
		logic signed [33:0] t;
		logic signed [33:0] v;
		ie = {1'b0, i};
		t  = '0;
		case (kind)
			KIND_SQUARE: v = (ie > QTR && ie < MID_HI) ? ONE34 : -ONE34;
			KIND_TRI: begin
				t = 34'(i) << SH_TRI;
				v = (i < HALF) ? t - ONE34 : THREE34 - t;
			end
			KIND_RAMP: begin
				t = 34'(i) << SH_RAMP;
				v = t - ONE34;
			end
			default: v = '0;
		endcase
		return v[DATA_W-1:0];
	endfunction

	// entry counter and table flag
	logic [AW-1:0]     cnt_q;
	logic              table_valid_q;

	// noise
	logic [DATA_W-1:0] x1_q;
	logic [DATA_W-1:0] x2_q;
	logic [DATA_W-1:0] x1_next;
	logic [DATA_W-1:0] noise_v;

	// smoothing
	logic signed [DATA_W-1:0] prev_q;
	logic signed [DATA_W-1:0] cur;
	logic signed [32:0]       diff;
	logic signed [48:0]       prod_s1;
	logic signed [48:0]       rnd;
	logic signed [33:0]       inc;
	logic signed [33:0]       sm_v34;
	logic [DATA_W-1:0]        sm_v;
	logic [DATA_W-1:0]        sm_abs;
	logic [DATA_W-1:0]        peak_q;

	// divider
	logic [DATA_W-1:0] mag;
	logic [61:0]       dvd;
	logic [DATA_W-1:0] rem_q;
	logic [QUO_W-1:0]  lo_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              sign_q;
	logic [32:0]       rem2;
	logic [32:0]       rem_sub;
	logic              ge;
	logic [DATA_W-1:0] q32;
	logic [DATA_W-1:0] nr_v;

	// RAM
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic [IDX_W+AW-1:0] idx_ext;
	logic [AW-1:0]     rd_idx;

	// read pipeline and output register
	logic                       rd_s1;
	logic                       out_free;
	logic signed [32:0]         rd_sum;
	logic signed [17:0]         rd_sh;
	logic signed [SAMPLE_W-1:0] rd_sample;

	assign x1_next = x1_q ^ x2_q;
	assign noise_v = {x2_q[DATA_W-1], x2_q[DATA_W-1:1]};

	assign cur    = shape_val(cfg.kind, cnt_q);
	assign diff   = {cur[DATA_W-1], cur} - {prev_q[DATA_W-1], prev_q};
	assign rnd    = prod_s1 + RND15;
	assign inc    = rnd[48:15];
	assign sm_v34 = {{2{prev_q[DATA_W-1]}}, prev_q} + inc;
	assign sm_v   = sm_v34[DATA_W-1:0];
	assign sm_abs = sm_v[DATA_W-1] ? DATA_W'(-sm_v) : sm_v;

	assign mag     = ram_rdata[DATA_W-1] ? DATA_W'(-ram_rdata) : ram_rdata;
	assign dvd     = {mag, 30'b0} + 62'(peak_q >> 1);
	assign rem2    = {rem_q, lo_q[QUO_W-1]};
	assign rem_sub = rem2 - {1'b0, peak_q};
	assign ge      = rem2 >= {1'b0, peak_q};
	assign q32     = {1'b0, quo_q};
	assign nr_v    = sign_q ? DATA_W'(-q32) : q32;

	assign idx_ext = (IDX_W+AW)'(req_index);
	assign rd_idx  = idx_ext[AW-1:0];

	always_comb begin
		ram_we    = cmd.fill_wr || cmd.sm_wr || cmd.nr_wr;
		ram_waddr = cnt_q;
		if (cmd.sm_wr) begin
			ram_wdata = sm_v;
		end else if (cmd.nr_wr) begin
			ram_wdata = nr_v;
		end else if (cfg.kind == KIND_NOISE) begin
			ram_wdata = noise_v;
		end else begin
			ram_wdata = cur;
		end
		ram_re    = cmd.rd_start || cmd.nr_rd;
		ram_raddr = cmd.rd_start ? rd_idx : cnt_q;
	end

	wtg_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TABLE_SIZE)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Q2.30 -> Q1.15, round half up, saturate; zero until a table is built
	always_comb begin
		rd_sum = {ram_rdata[DATA_W-1], ram_rdata} + RND_RD;
		rd_sh  = rd_sum[32:15];
		if (!table_valid_q) begin
			rd_sample = '0;
		end else if (rd_sh > SAT_HI) begin
			rd_sample = SAT_HI[SAMPLE_W-1:0];
		end else if (rd_sh < SAT_LO) begin
			rd_sample = SAT_LO[SAMPLE_W-1:0];
		end else begin
			rd_sample = rd_sh[SAMPLE_W-1:0];
		end
	end

	assign out_free = !rsp_valid || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			table_valid_q <= 1'b0;
			rd_s1         <= 1'b0;
			rsp_valid     <= 1'b0;
		end else begin
			if (cmd.build_start) begin
				cnt_q <= '0;
			end else if (cmd.fill_wr || cmd.sm_wr || cmd.nr_wr) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.build_ack) begin
				table_valid_q <= 1'b1;
			end
			if (cmd.rd_start) begin
				rd_s1 <= 1'b1;
			end else if (out_free) begin
				rd_s1 <= 1'b0;
			end
			if ((rd_s1 && out_free) || cmd.build_ack) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1 && out_free) begin
			rsp_sample <= rd_sample;
			rsp_built  <= 1'b0;
		end else if (cmd.build_ack) begin
			rsp_sample <= '0;
			rsp_built  <= 1'b1;
		end
		if (cmd.build_start) begin
			x1_q   <= NOISE_SEED1;
			x2_q   <= NOISE_SEED2;
			prev_q <= shape_val(cfg.kind, LAST);
			peak_q <= '0;
		end else begin
			if (cmd.fill_wr) begin
				x1_q <= x1_next;
				x2_q <= x2_q + x1_next;
			end
			if (cmd.sm_wr) begin
				prev_q <= sm_v;
				if (sm_abs > peak_q) begin
					peak_q <= sm_abs;
				end
			end
		end
		if (cmd.sm_mul) begin
			prod_s1 <= diff * $signed({1'b0, cfg.coef});
		end
		if (cmd.nr_ld) begin
			rem_q  <= {1'b0, dvd[61:31]};
			lo_q   <= dvd[30:0];
			sign_q <= ram_rdata[DATA_W-1];
			quo_q  <= '0;
			dcnt_q <= DCNT_W'(QUO_W - 1);
		end else if (cmd.nr_step) begin
			rem_q  <= ge ? rem_sub[DATA_W-1:0] : rem2[DATA_W-1:0];
			lo_q   <= {lo_q[QUO_W-2:0], 1'b0};
			quo_q  <= {quo_q[QUO_W-2:0], ge};
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	assign sts.last       = (cnt_q == LAST);
	assign sts.div_last   = (dcnt_q == '0);
	assign sts.peak_zero  = (peak_q == '0);
	assign sts.out_free   = out_free;
	assign sts.rd_pending = rd_s1;

endmodule

`default_nettype wire

### rtl/core/wavetable_generator.sv
// Wavetable generator top level: APB registers, sequencer and datapath.
// Depends on wtg_pkg, wtg_if, wtg_regs, wtg_ctrl, wtg_dp, wtg_ram.
//
// channel  direction  handshake      payload
// req      in         valid/ready    action, index
// rsp      out        valid/ready    sample, built
// apb      in         psel/penable   paddr, pwdata -> prdata
//
// Reads: one item per cycle while the output is not stalled; each result passes
// the table RAM read register, then the output register. Without smoothing a build
// does one RAM write per entry. With smoothing: a multiply and a write per
// entry for the smoothing pass, then per entry a RAM read, a divider load, the
// 31-step restoring divider of the peak normalization and a write. A result
// waiting on rsp stalls new items only when the RAM read register is also
// occupied. Reset clears control state and the registers; the table is not
// cleared.
`default_nettype none

module wavetable_generator #(
	parameter int unsigned TABLE_SIZE = wtg_pkg::TABLE_SIZE_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	wtg_req_if.sink                     req,
	wtg_rsp_if.source                   rsp,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [wtg_pkg::PADDR_W-1:0]  paddr,
	input  wire [wtg_pkg::PDATA_W-1:0]  pwdata,
	output logic [wtg_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import wtg_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	wtg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	wtg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req.valid),
		.req_action(req.action),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wtg_dp #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.req_index (req.index),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_sample(rsp.sample),
		.rsp_built (rsp.built)
	);

endmodule

`default_nettype wire

### rtl/core/wtg_checker.sv
// Port-level checker for the wavetable generator, bound to the top level.
// Depends on wtg_pkg and wavetable_generator_defines.svh.
`default_nettype none
`include "wavetable_generator_defines.svh"

module wtg_port_checks (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                req_valid,
	input wire                                req_ready,
	input wire                                req_action,
	input wire                                rsp_valid,
	input wire                                rsp_ready,
	input wire signed [wtg_pkg::SAMPLE_W-1:0] rsp_sample,
	input wire                                rsp_built,
	input wire                                psel,
	input wire                                penable,
	input wire                                pwrite,
	input wire [wtg_pkg::PADDR_W-1:0]         paddr,
	input wire [wtg_pkg::PDATA_W-1:0]         pwdata,
	input wire [wtg_pkg::PDATA_W-1:0]         prdata
);
	import wtg_pkg::*;

	property p_rsp_stable;
		rsp_valid && !rsp_ready |=> $stable(rsp_sample) && $stable(rsp_built);
	endproperty

	property p_kind_readback;
		psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_KIND
			##1 psel && !pwrite && paddr == $past(paddr)
			|-> prdata[KIND_W-1:0] == $past(pwdata[KIND_W-1:0]);
	endproperty

	`WTG_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid)
	`WTG_ASSERT(a_rsp_stable, clk, arst_n, p_rsp_stable)
	`WTG_ASSERT_NEVER(a_build_zero, clk, arst_n, rsp_valid && rsp_built && rsp_sample != '0)
	`WTG_ASSERT(a_build_busy, clk, arst_n, req_valid && req_ready && req_action == ACT_BUILD |=> !req_ready)
	`WTG_ASSERT(a_kind_readback, clk, arst_n, p_kind_readback)

endmodule

bind wavetable_generator wtg_port_checks u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_action(req.action),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_sample(rsp.sample),
	.rsp_built (rsp.built),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);

`default_nettype wire

### test/wtg_checker.sv
`timescale 1ns / 1ps
// Checker for the wavetable generator: snoops the APB port and both item
// channels, keeps its own table and compares each response in order.
// Depends on wtg_pkg and wtg_if.

module wtg_checker
	import wtg_pkg::*;
#(
	parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	wtg_req_if                 req,
	wtg_rsp_if                 rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 pending,
	output int                 mismatches
);

	localparam longint Q30_ONE = longint'(1) << 30;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       built;
	} rsp_t;

	logic signed [DATA_W-1:0] wave_tab [TABLE_SIZE];
	logic                     have_table;
	logic [KIND_W-1:0]        kind;
	logic                     soft_en;
	logic [COEF_W-1:0]        coef;
	rsp_t                     rsp_due [$];
	rsp_t                     want;
	rsp_t                     got;
	int                       bad;

	function automatic void build_wave();
		longint      n;
		longint      i;
		longint      v;
		longint      prev;
		longint      cur;
		longint      a;
		longint      peak;
		longint      m;
		longint      q;
		logic [31:0] x1;
		logic [31:0] x2;
		n = TABLE_SIZE;
		x1 = NOISE_SEED1;
		x2 = NOISE_SEED2;
		for (i = 0; i < n; i++) begin
			case (kind)
				KIND_SQUARE: v = (i > n / 4 && i < n / 4 + n / 2) ? Q30_ONE : -Q30_ONE;
				KIND_TRI: v = (i < n / 2) ? (4 * i * Q30_ONE) / n - Q30_ONE
				                          : 3 * Q30_ONE - (4 * i * Q30_ONE) / n;
				KIND_RAMP: v = (2 * i * Q30_ONE) / n - Q30_ONE;
				default: begin
					x1 = x1 ^ x2;
					v = longint'($signed(x2)) >>> 1;
					x2 = x2 + x1;
				end
			endcase
			wave_tab[i] = v[31:0];
		end
		if (!soft_en || kind == KIND_NOISE)
			return;
		// one-pole smoothing, wraps around from the last raw entry
		a = coef;
		prev = wave_tab[n - 1];
		for (i = 0; i < n; i++) begin
			cur = wave_tab[i];
			v = prev + (((cur - prev) * a + 16384) >>> 15);
			wave_tab[i] = v[31:0];
			prev = v;
		end
		peak = 0;
		for (i = 0; i < n; i++) begin
			v = wave_tab[i];
			m = v < 0 ? -v : v;
			if (m > peak)
				peak = m;
		end
		if (peak == 0)
			return;
		for (i = 0; i < n; i++) begin
			v = wave_tab[i];
			m = v < 0 ? -v : v;
			q = (m * Q30_ONE + peak / 2) / peak;
			v = v < 0 ? -q : q;
			wave_tab[i] = v[31:0];
		end
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] read_q15(input logic [IDX_W-1:0] idx);
		longint s;
		if (!have_table)
			return '0;
		s = (longint'(wave_tab[idx % TABLE_SIZE]) + 16384) >>> 15;
		if (s > 32767)
			s = 32767;
		if (s < -32768)
			s = -32768;
		return s[SAMPLE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind = KIND_RST;
			soft_en = SOFT_RST;
			coef = COEF_RST;
			have_table = 1'b0;
			rsp_due.delete();
			bad = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			if (req.valid && req.ready) begin
				if (req.action == ACT_BUILD) begin
					build_wave();
					have_table = 1'b1;
					want.sample = '0;
					want.built = 1'b1;
				end else begin
					want.sample = read_q15(req.index);
					want.built = 1'b0;
				end
				rsp_due.push_back(want);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_KIND: kind = pwdata[KIND_W-1:0];
					REG_SOFT: soft_en = pwdata[0];
					REG_COEF: coef = pwdata[COEF_W-1:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				got.sample = rsp.sample;
				got.built = rsp.built;
				if (rsp_due.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("unexpected item: sample %0d built %0b", got.sample, got.built);
				end else begin
					want = rsp_due.pop_front();
					if (got.sample !== want.sample || got.built !== want.built) begin
						bad++;
						if (bad <= 10)
							$display("mismatch: sample exp %0d got %0d, built exp %0b got %0b",
								want.sample, got.sample, want.built, got.built);
					end
				end
			end
			pending <= rsp_due.size();
			mismatches <= bad;
		end
	end

endmodule

### test/tb_wavetable_generator.sv
`timescale 1ns / 1ps
// Testbench top for the wavetable generator: clock, reset, APB setup,
// directed and random build/read items, verdict. Depends on wtg_pkg,
// wtg_if, wavetable_generator and wtg_checker.

module tb_wavetable_generator;
	import wtg_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int SEGS_PER_PHASE = 4;
	localparam int READS_PER_SEG = 145;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 pending;
	int                 mismatches;
	int                 tx_idle_pct;
	int                 rx_stall_pct;
	logic               soft_now;

	wtg_req_if req_ch();
	wtg_rsp_if rsp_ch();

	wavetable_generator uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	wtg_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pending    (pending),
		.mismatches (mismatches)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	task automatic send_item(input logic act, input logic [IDX_W-1:0] idx);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.index <= idx;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// stop sending and wait until every response is back
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] r, input logic [PDATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({r, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [KIND_W-1:0] k, input logic s,
		input logic [COEF_W-1:0] c);
		drain();
		reg_write(REG_KIND, PDATA_W'(k));
		reg_write(REG_SOFT, PDATA_W'(s));
		reg_write(REG_COEF, PDATA_W'(c));
		soft_now = s;
	endtask

	initial begin
		int               phase;
		int               seg;
		int               n;
		logic [KIND_W-1:0] k;
		logic              s;
		logic [COEF_W-1:0] c;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_BUILD;
		req_ch.index = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		soft_now = SOFT_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reads before any build give zero
		send_item(ACT_READ, '0);
		send_item(ACT_READ, '1);
		// reset config: square edges around N/4 and 3N/4
		send_item(ACT_BUILD, '0);
		send_item(ACT_READ, IDX_W'(256));
		send_item(ACT_READ, IDX_W'(257));
		send_item(ACT_READ, IDX_W'(767));
		send_item(ACT_READ, IDX_W'(768));
		set_config(KIND_TRI, 1'b0, COEF_RST);
		send_item(ACT_BUILD, '1);
		send_item(ACT_READ, '0);
		send_item(ACT_READ, IDX_W'(512));
		send_item(ACT_READ, '1);
		set_config(KIND_RAMP, 1'b0, COEF_RST);
		send_item(ACT_BUILD, IDX_W'($urandom));
		send_item(ACT_READ, '0);
		send_item(ACT_READ, '1);
		// smoothing is skipped for noise
		set_config(KIND_NOISE, 1'b1, '1);
		send_item(ACT_BUILD, IDX_W'($urandom));
		send_item(ACT_READ, IDX_W'(1));
		send_item(ACT_READ, IDX_W'(1022));
		set_config(KIND_SQUARE, 1'b1, '1);
		send_item(ACT_BUILD, IDX_W'($urandom));
		send_item(ACT_READ, '0);
		send_item(ACT_READ, IDX_W'(512));
		// unmapped register write is dropped; zero coefficient flattens the table
		drain();
		reg_write(REG_UNMAPPED, '1);
		set_config(KIND_RAMP, 1'b1, '0);
		send_item(ACT_BUILD, IDX_W'($urandom));
		send_item(ACT_READ, IDX_W'(5));
		send_item(ACT_READ, '1);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 17;
					rx_stall_pct = 61;
				end
				1: begin
					tx_idle_pct = 61;
					rx_stall_pct = 17;
				end
				default: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
			endcase
			for (seg = 0; seg < SEGS_PER_PHASE; seg++) begin
				// smoothed builds are slow: one segment per phase
				s = (seg == 1);
				k = s ? KIND_W'($urandom_range(2)) : KIND_W'($urandom_range(3));
				case ($urandom_range(3))
					0: c = '0;
					1: c = COEF_W'(1);
					2: c = '1;
					default: c = COEF_W'($urandom);
				endcase
				set_config(k, s, c);
				send_item(ACT_BUILD, IDX_W'($urandom));
				for (n = 0; n < READS_PER_SEG; n++) begin
					if (!soft_now && $urandom_range(49) == 0)
						send_item(ACT_BUILD, IDX_W'($urandom));
					else
						send_item(ACT_READ, IDX_W'($urandom));
				end
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### wavetable_generator.f
+incdir+rtl/core
rtl/core/wtg_pkg.sv
rtl/core/wtg_if.sv
rtl/core/wtg_ram.sv
rtl/core/wtg_regs.sv
rtl/core/wtg_ctrl.sv
rtl/core/wtg_dp.sv
rtl/core/wavetable_generator.sv
rtl/core/wtg_checker.sv
test/wtg_checker.sv
test/tb_wavetable_generator.sv
